// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and constants for the round-robin thread scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int THR_W  = 6;    // thread index and thread count width
    localparam int DATA_W = 32;   // delay counter width
    localparam int MASK_W = 32;   // ready mask port width

    localparam logic [THR_W-1:0] NONE_RUNNING = 6'd63;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_DELAY = 2'd1;
    localparam logic [1:0] OP_SCHED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCHED,
        ST_OUT
    } rrts_state_t;

endpackage

// ===== hdl/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/round_robin_thread_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// round-robin scheduler over a ready bitmap with per-thread delay counters
// ----------------------------------------------------------------------------
// One item at a time: s_ready is high only while the sequencer is idle, and
// the result item sits in an output register until m_ready takes it. A tick
// walks the delay counter ram one thread per cycle through a one-deep read
// pipeline, then presents the result. A schedule (or delay then schedule),
// once accepted in idle, steps the round-robin index by one thread per cycle
// through a single incrementer and compare until it finds a ready thread, or
// picks idle when nothing is ready, and then presents the result. Code 3 and
// a refused delay offer their result from the edge that accepts them. Writing
// cfg_wdata (only while idle) readies every registered thread at once and
// clears all delay counters through per-entry valid bits, so no clearing pass
// is needed.
module round_robin_thread_scheduler_core
    import rrts_pkg::*;
#(
    parameter int MAX_THREADS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              cfg_we,
    input  logic [THR_W-1:0]  cfg_wdata,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [DATA_W-1:0] s_delay_ticks,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [THR_W-1:0]  m_next_thread,
    output logic              m_switch_request,
    output logic [MASK_W-1:0] m_ready_mask,
    output logic              m_delay_ignored
);

    // bit index into the ready and valid vectors (thread i lives at bit i-1)
    localparam int RB_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    // largest thread count: MAX_THREADS + 1, capped at 63 for the 6-bit register
    localparam logic [THR_W-1:0] COUNT_MAX =
        THR_W'((MAX_THREADS + 1 > 63) ? 63 : MAX_THREADS + 1);

    rrts_state_t              state_reg, state_next;
    logic [THR_W-1:0]         count_reg, count_next;
    logic [MAX_THREADS-1:0]   ready_reg, ready_next;
    logic [MAX_THREADS-1:0]   cvalid_reg, cvalid_next;   // counter entry written since clear
    logic [THR_W-1:0]         rr_reg, rr_next;
    logic [THR_W-1:0]         run_reg, run_next;
    logic [THR_W-1:0]         tick_idx_reg, tick_idx_next;
    logic                     pend_reg, pend_next;
    logic [THR_W-1:0]         pend_thr_reg, pend_thr_next;

    logic                     m_valid_reg, m_valid_next;
    logic [THR_W-1:0]         nt_reg, nt_next;
    logic                     sw_reg, sw_next;
    logic [MASK_W-1:0]        mask_reg, mask_next;
    logic                     ign_reg, ign_next;

    // counter ram port
    logic                     ram_we;
    logic [RB_W-1:0]          ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic                     ram_re;
    logic [RB_W-1:0]          ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;

    // working values
    logic [THR_W-1:0]         cfg_sat;
    logic [MAX_THREADS-1:0]   reg_mask;
    logic                     load_out;
    logic                     out_sw;
    logic                     out_ign;
    logic [THR_W-1:0]         out_thr;
    logic                     tick_issue;
    logic [DATA_W-1:0]        cnt_cur;
    logic [DATA_W-1:0]        cnt_dec;
    logic [THR_W:0]           rr_inc;
    logic [THR_W-1:0]         cand;
    logic [63:0]              mask_wide;

    function automatic logic [RB_W-1:0] bit_idx(input logic [THR_W-1:0] thr);
        logic [THR_W-1:0] t;
        t = thr - THR_W'(1);
        return t[RB_W-1:0];
    endfunction

    rrts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_THREADS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // saturated count and registered-thread mask for a config write
    always_comb begin
        cfg_sat = cfg_wdata;
        if (cfg_sat == '0) begin
            cfg_sat = THR_W'(1);
        end
        if (cfg_sat > COUNT_MAX) begin
            cfg_sat = COUNT_MAX;
        end
        for (int i = 0; i < MAX_THREADS; i++) begin
            reg_mask[i] = (i + 1) < int'(cfg_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= THR_W'(1);
            ready_reg   <= '0;
            cvalid_reg  <= '0;
            rr_reg      <= '0;
            run_reg     <= NONE_RUNNING;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ready_reg   <= ready_next;
            cvalid_reg  <= cvalid_next;
            rr_reg      <= rr_next;
            run_reg     <= run_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and walk registers, no reset needed
    always_ff @(posedge aclk) begin
        tick_idx_reg <= tick_idx_next;
        pend_thr_reg <= pend_thr_next;
        nt_reg       <= nt_next;
        sw_reg       <= sw_next;
        mask_reg     <= mask_next;
        ign_reg      <= ign_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ready_next    = ready_reg;
        cvalid_next   = cvalid_reg;
        rr_next       = rr_reg;
        run_next      = run_reg;
        tick_idx_next = tick_idx_reg;
        pend_next     = pend_reg;
        pend_thr_next = pend_thr_reg;
        m_valid_next  = m_valid_reg;
        nt_next       = nt_reg;
        sw_next       = sw_reg;
        mask_next     = mask_reg;
        ign_next      = ign_reg;

        ram_we    = 1'b0;
        ram_waddr = bit_idx(pend_thr_reg);
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = bit_idx(tick_idx_reg);

        load_out = 1'b0;
        out_sw   = 1'b0;
        out_ign  = 1'b0;
        out_thr  = rr_reg;

        tick_issue = tick_idx_reg < count_reg;
        cnt_cur    = cvalid_reg[bit_idx(pend_thr_reg)] ? ram_rdata : '0;
        cnt_dec    = cnt_cur - DATA_W'(1);
        rr_inc     = {1'b0, rr_reg} + (THR_W+1)'(1);
        cand       = (rr_inc >= {1'b0, count_reg}) ? THR_W'(1) : rr_inc[THR_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (cfg_we) begin
                    count_next  = cfg_sat;
                    ready_next  = reg_mask;
                    cvalid_next = '0;
                end
                if (s_valid) begin
                    case (s_operation)
                        OP_TICK: begin
                            tick_idx_next = THR_W'(1);
                            pend_next     = 1'b0;
                            state_next    = ST_TICK;
                        end
                        OP_DELAY: begin
                            if (rr_reg == '0 || rr_reg >= count_reg) begin
                                // idle or unregistered thread: refuse the delay
                                out_ign  = 1'b1;
                                load_out = 1'b1;
                            end else begin
                                ram_we                       = 1'b1;
                                ram_waddr                    = bit_idx(rr_reg);
                                ram_wdata                    = s_delay_ticks;
                                cvalid_next[bit_idx(rr_reg)] = 1'b1;
                                ready_next[bit_idx(rr_reg)]  = 1'b0;
                                state_next                   = ST_SCHED;
                            end
                        end
                        OP_SCHED: begin
                            state_next = ST_SCHED;
                        end
                        default: begin
                            // unused code: present a result, no scheduler state change
                            load_out = 1'b1;
                        end
                    endcase
                end
            end

            ST_TICK: begin
                // issue one counter read per cycle
                if (tick_issue) begin
                    ram_re        = 1'b1;
                    pend_next     = 1'b1;
                    pend_thr_next = tick_idx_reg;
                    tick_idx_next = tick_idx_reg + THR_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
                // retire the counter read last cycle
                if (pend_reg && cnt_cur != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = bit_idx(pend_thr_reg);
                    ram_wdata = cnt_dec;
                    if (cnt_dec == '0) begin
                        ready_next[bit_idx(pend_thr_reg)] = 1'b1;
                    end
                end
                if (!tick_issue && !pend_reg) begin
                    load_out = 1'b1;
                end
            end

            ST_SCHED: begin
                if (ready_reg == '0) begin
                    rr_next  = '0;
                    out_thr  = '0;
                    out_sw   = run_reg != '0;
                    run_next = '0;
                    load_out = 1'b1;
                end else begin
                    // one round-robin step per cycle
                    rr_next = cand;
                    if (ready_reg[bit_idx(cand)]) begin
                        out_thr  = cand;
                        out_sw   = run_reg != cand;
                        run_next = cand;
                        load_out = 1'b1;
                    end
                end
            end

            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        mask_wide = 64'(ready_next);
        if (load_out) begin
            m_valid_next = 1'b1;
            nt_next      = out_thr;
            sw_next      = out_sw;
            ign_next     = out_ign;
            mask_next    = mask_wide[MASK_W-1:0];
            state_next   = ST_OUT;
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_next_thread    = nt_reg;
    assign m_switch_request = sw_reg;
    assign m_ready_mask     = mask_reg;
    assign m_delay_ignored  = ign_reg;

endmodule
